@@ rtl/factor_base_smoothness_test_assert.svh @@
// ----------------------------------------------------------------------------
// factor_base_smoothness_test_assert.svh
// Assertion macros shared by the factor-base smoothness tester.
// ----------------------------------------------------------------------------
`ifndef FACTOR_BASE_SMOOTHNESS_TEST_ASSERT_SVH
`define FACTOR_BASE_SMOOTHNESS_TEST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FBST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbst assertion failed");

// next-cycle implication, disabled during reset
`define FBST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbst assertion failed");

`endif

@@ rtl/fbst_pkg.sv @@
// ----------------------------------------------------------------------------
// fbst_pkg
// Types and constants of the factor-base smoothness tester.
// ----------------------------------------------------------------------------
package fbst_pkg;

  localparam int VAL_W       = 32;
  localparam int PROD_W      = 64;
  localparam int SLOT_W      = 5;
  localparam int PRIME_IN_W  = 16;
  localparam int PCOUNT_W    = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int DIV_CNT_W   = 7;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE   = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NARROW = 7'd32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_COUNT = 1'd1;

  localparam logic [VAL_W-1:0]    MODULUS_RST     = 32'd2;
  localparam logic [PCOUNT_W-1:0] PRIME_COUNT_RST = 6'd1;

  typedef struct packed {
    logic                  command;
    logic [SLOT_W-1:0]     slot;
    logic [PRIME_IN_W-1:0] prime;
    logic [VAL_W-1:0]      candidate;
  } in_payload_t;

  typedef struct packed {
    logic [VAL_W-1:0] tested_value;
    logic [VAL_W-1:0] residue;
    logic             smooth;
    logic [VAL_W-1:0] parity_vector;
  } out_payload_t;

  // wide: 64-bit dividend, 64 steps; otherwise 32-bit dividend, 32 steps
  typedef struct packed {
    logic start;
    logic wide;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MODSTART,
    ST_REDUCE,
    ST_FETCH,
    ST_CHECK,
    ST_TRIAL
  } state_t;

endpackage

@@ rtl/fbst_div.sv @@
// ----------------------------------------------------------------------------
// fbst_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "factor_base_smoothness_test_assert.svh"

module fbst_div
  import fbst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_cmd_t          cmd,
  input  logic [PROD_W-1:0] dividend,
  input  logic [VAL_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [VAL_W-1:0]  quotient,
  output logic [VAL_W-1:0]  remainder
);

  logic [PROD_W-1:0]    q_r, q_nxt;
  logic [VAL_W-1:0]     r_r, r_nxt;
  logic [VAL_W-1:0]     d_r, d_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [VAL_W:0]       shifted;
  logic [VAL_W:0]       diff;
  logic                 fits;

  assign shifted = {r_r, q_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign fits    = shifted >= {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      q_nxt    = cmd.wide ? dividend : {dividend[VAL_W-1:0], {VAL_W{1'b0}}};
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = cmd.wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[PROD_W-2:0], fits};
      r_nxt   = fits ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r[VAL_W-1:0];
  assign remainder = r_r;

  `FBST_ASSERT_NXT(a_start_busy, clk, rst_n, cmd.start, busy_r)
  `FBST_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `FBST_ASSERT_IMP(a_busy_count, clk, rst_n, busy_r, cnt_r != '0)

endmodule

@@ rtl/fbst_table.sv @@
// ----------------------------------------------------------------------------
// fbst_table
// Factor-base prime store, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbst_table
  import fbst_pkg::*;
#(
  parameter int MAX_PRIMES = 32,
  parameter int PRIME_BITS = 16,
  parameter int ADDR_W     = 5
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [PRIME_BITS-1:0] wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [PRIME_BITS-1:0] rd_data
);

  logic [PRIME_BITS-1:0] mem [MAX_PRIMES];
  logic [PRIME_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/factor_base_smoothness_test.sv @@
// ----------------------------------------------------------------------------
// factor_base_smoothness_test
// Trial-division smoothness test of k*k mod n over a table of primes.
// ----------------------------------------------------------------------------
// usage:
//   in_data carries one transaction; it is taken on a clock edge with start
//   high and busy low. a load (command 0) writes a prime into the table in
//   that same edge, keeps busy low and gives no result. a test (command 1)
//   raises busy until its result is out.
//   out_valid marks the result for exactly one cycle; the receiver cannot
//   stall it, so it must take the result in that cycle.
//   cfg_we/cfg_index/cfg_wdata write modulus (index 0) and prime_count
//   (index 1); the user writes them only while the block is idle (not enforced).
// sequence of a test, all work on one shared bit-serial divider:
//   square and setup, reduction mod n (skipped when n is below 2),
//   then for each table prime in use a fetch and check plus division attempts
//   (one failing attempt per prime, one more for every time it divides);
//   table entries below 2 get no attempt. the result is registered at the end.
// reset: modulus 2, prime_count 1, no transaction pending. the prime table
//   holds nothing useful until loaded.
// ----------------------------------------------------------------------------
`include "factor_base_smoothness_test_assert.svh"

module factor_base_smoothness_test
  import fbst_pkg::*;
#(
  parameter int MAX_PRIMES = 32,
  parameter int PRIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_payload_t          in_data,
  output logic                 out_valid,
  output out_payload_t         out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CNT_W  = $clog2(MAX_PRIMES + 1);

  state_t                state_r, state_nxt;
  logic [VAL_W-1:0]      modulus_r;
  logic [PCOUNT_W-1:0]   prime_count_r;
  logic [VAL_W-1:0]      k_r, k_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [VAL_W-1:0]      residue_r, residue_nxt;
  logic [VAL_W-1:0]      rest_r, rest_nxt;
  logic [VAL_W-1:0]      parity_r, parity_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_payload_t          out_data_r, out_data_nxt;
  logic [CNT_W-1:0]      eff_count;
  logic                  accept;
  logic                  tbl_we;
  logic [PRIME_BITS-1:0] tbl_rd_data;
  div_cmd_t              div_cmd;
  div_stat_t             div_stat;
  logic [PROD_W-1:0]     div_dividend;
  logic [VAL_W-1:0]      div_divisor;
  logic [VAL_W-1:0]      div_quot;
  logic [VAL_W-1:0]      div_rem;

  assign accept = start && (state_r == ST_IDLE);
  assign tbl_we = accept && (in_data.command == CMD_LOAD) && (int'(in_data.slot) < MAX_PRIMES);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= MODULUS_RST;
      prime_count_r <= PRIME_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus_r     <= cfg_wdata;
        REG_PRIME_COUNT: prime_count_r <= cfg_wdata[PCOUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if (int'(prime_count_r) > MAX_PRIMES) begin
      eff_count = CNT_W'(MAX_PRIMES);
    end else begin
      eff_count = CNT_W'(prime_count_r);
    end
  end

  fbst_table #(
    .MAX_PRIMES (MAX_PRIMES),
    .PRIME_BITS (PRIME_BITS),
    .ADDR_W     (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (ADDR_W'(in_data.slot)),
    .wr_data (PRIME_BITS'(in_data.prime)),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (tbl_rd_data)
  );

  fbst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (div_cmd),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    residue_nxt   = residue_r;
    rest_nxt      = rest_r;
    parity_nxt    = parity_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    div_cmd       = '0;
    div_dividend  = prod_r;
    div_divisor   = VAL_W'(tbl_rd_data);

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.command == CMD_TEST)) begin
          k_nxt     = in_data.candidate;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        prod_nxt  = PROD_W'(k_r) * PROD_W'(k_r);
        state_nxt = ST_MODSTART;
      end
      ST_MODSTART: begin
        idx_nxt    = '0;
        parity_nxt = '0;
        if (modulus_r < VAL_W'(2)) begin
          residue_nxt = '0;
          rest_nxt    = '0;
          state_nxt   = ST_FETCH;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.wide  = 1'b1;
          div_divisor   = modulus_r;
          state_nxt     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (div_stat.done) begin
          residue_nxt = div_rem;
          rest_nxt    = div_rem;
          state_nxt   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // table read of slot idx_r lands in the next cycle
        if ((idx_r < eff_count) && (rest_r != '0)) begin
          state_nxt = ST_CHECK;
        end else begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.tested_value  = k_r;
          out_data_nxt.residue       = residue_r;
          out_data_nxt.smooth        = (rest_r == VAL_W'(1));
          out_data_nxt.parity_vector = parity_r;
          state_nxt                  = ST_IDLE;
        end
      end
      ST_CHECK: begin
        // entries holding 0 or 1 are not primes and are skipped
        if (tbl_rd_data > PRIME_BITS'(1)) begin
          div_cmd.start = 1'b1;
          div_dividend  = PROD_W'(rest_r);
          state_nxt     = ST_TRIAL;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_FETCH;
        end
      end
      ST_TRIAL: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            rest_nxt      = div_quot;
            parity_nxt    = parity_r ^ (VAL_W'(1) << idx_r);
            div_cmd.start = 1'b1;
            div_dividend  = PROD_W'(div_quot);
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    prod_r     <= prod_nxt;
    residue_r  <= residue_nxt;
    rest_r     <= rest_nxt;
    parity_r   <= parity_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FBST_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `FBST_ASSERT_NXT(a_test_busy, clk, rst_n, accept && (in_data.command == CMD_TEST), busy)
  `FBST_ASSERT_NXT(a_load_silent, clk, rst_n, accept && (in_data.command == CMD_LOAD), !out_valid_r)
  `FBST_ASSERT_IMP(a_trial_div, clk, rst_n, state_r == ST_TRIAL, div_stat.busy || div_stat.done)

endmodule
